/* hdl/qpse_pkg.sv */
// Shared constants, codes and types for the quadrature position and speed estimator.
package qpse_pkg;

  // Field and state widths
  localparam int TIME_BITS = 32;
  localparam int POS_BITS  = 32;
  localparam int PPR_W     = 16;
  localparam int DIR_W     = 2;
  localparam int RPM_W     = 35;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // Speed division: 60e6 * 256 / (period * ppr)
  localparam int DVD_W = 34;
  localparam int DVS_W = TIME_BITS + PPR_W;
  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [DVD_W-1:0] RPM_NUM_Q8 = 34'd15360000000;

  // IIR filter, Q1.15 coefficients 0.854 and 0.0728
  localparam int COEF_W  = 16;
  localparam int PROD_W  = RPM_W + COEF_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int FRAC_Q  = 15;
  localparam int RND_W   = ACC_W - FRAC_Q;
  localparam logic signed [COEF_W-1:0] COEF_FB  = 16'sd27984;
  localparam logic signed [COEF_W-1:0] COEF_FF  = 16'sd2386;
  localparam logic signed [ACC_W-1:0]  RND_HALF = 52'sd16384;

  // Item kinds
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PPR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EN  = 1'd1;

  // Direction codes
  localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_POS  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_NEG  = 2'sb11;

  // Filter term selection
  localparam logic [1:0] TERM_FB   = 2'd0;
  localparam logic [1:0] TERM_RAW  = 2'd1;
  localparam logic [1:0] TERM_PREV = 2'd2;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_FILT = 6'b001000,
    ST_RND  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  // Divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

/* hdl/qpse_in_if.sv */
// Input channel: edge and speed-read items.
interface qpse_in_if;
  import qpse_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic                 phase_b_level;
  logic [TIME_BITS-1:0] timestamp_us;

  modport source (output valid, req_type, phase_b_level, timestamp_us, input ready);
  modport sink   (input valid, req_type, phase_b_level, timestamp_us, output ready);
endinterface

/* hdl/qpse_out_if.sv */
// Result channel: position, direction and filtered speed.
interface qpse_out_if;
  import qpse_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] position;
  logic signed [DIR_W-1:0]    direction;
  logic signed [RPM_W-1:0]    speed_rpm_q8;

  modport source (output valid, position, direction, speed_rpm_q8, input ready);
  modport sink   (input valid, position, direction, speed_rpm_q8, output ready);
endinterface

/* hdl/qpse_div.sv */
// Restoring divider, one quotient bit per cycle.
module qpse_div import qpse_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_sts_t         sts,
  output logic [DVD_W-1:0] quotient
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             fits;

  // Trial subtract of the divisor from the shifted remainder
  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = !diff[DVS_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (ctl.start) begin
      // Load operands and clear the remainder
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W - 1);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      // Retire one quotient bit
      rem_nxt = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

/* hdl/quadrature_position_speed_estimator_top.sv */
// Quadrature encoder position counter with period-based filtered speed.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+-----------------------------------------
//   in_chan   | in  | valid/ready        | req_type, phase_b_level, timestamp_us
//   out_chan  | out | valid/ready        | position, direction, speed_rpm_q8
//   cfg_*     | in  | cfg_we             | cfg_index, cfg_wdata
//
// An edge item or a disabled read: result presented in the cycle after accept.
// An enabled read with a direction starts the divider on the period by pulses
// product, waits for done after its 34 quotient bits, passes the three filter
// terms through the filter multiplier, rounds, then presents the result. A read
// with no direction skips the divider and goes straight to the filter.
// in_chan is not ready until the result is taken; sync active-low reset.
module quadrature_position_speed_estimator_top import qpse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  qpse_in_if.sink              in_chan,
  qpse_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [PPR_W-1:0]            ppr_r, ppr_nxt;
  logic                        en_r, en_nxt;
  logic [POS_BITS-1:0]         pos_r, pos_nxt;
  logic signed [DIR_W-1:0]     dir_r, dir_nxt;
  logic [TIME_BITS-1:0]        prev_time_r, prev_time_nxt;
  logic [TIME_BITS-1:0]        period_r, period_nxt;
  logic signed [RPM_W-1:0]     filt_r, filt_nxt;
  logic signed [RPM_W-1:0]     prev_raw_r, prev_raw_nxt;
  logic signed [RPM_W-1:0]     raw_r, raw_nxt;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic [1:0]                  term_r, term_nxt;
  logic [POS_BITS-1:0]         out_pos_r, out_pos_nxt;
  logic signed [DIR_W-1:0]     out_dir_r, out_dir_nxt;
  logic signed [RPM_W-1:0]     out_spd_r, out_spd_nxt;

  logic                        in_acc;
  logic [TIME_BITS-1:0]        period_eff;
  logic [PPR_W-1:0]            ppr_eff;
  logic [DVS_W-1:0]            divisor;
  div_ctl_t                    div_ctl;
  div_sts_t                    div_sts;
  logic [DVD_W-1:0]            quotient;
  logic signed [RPM_W-1:0]     mag;
  logic signed [RPM_W-1:0]     mul_a;
  logic signed [COEF_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc_rnd;
  logic signed [RND_W-1:0]     rnd;
  logic signed [RPM_W-1:0]     sat;

  assign in_acc = in_chan.valid && in_chan.ready;

  // Zero period and zero pulses count read as one
  assign period_eff = (period_r == '0) ? TIME_BITS'(1) : period_r;
  assign ppr_eff    = (ppr_r == '0) ? PPR_W'(1) : ppr_r;
  assign divisor    = DVS_W'(period_eff) * DVS_W'(ppr_eff);

  // Divider runs 60e6*256 / (period * ppr)
  assign div_ctl.start = (state_r == ST_MUL);

  qpse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (RPM_NUM_Q8),
    .divisor  (divisor),
    .sts      (div_sts),
    .quotient (quotient)
  );

  assign mag = $signed({1'b0, quotient});

  // Shared filter multiplier, one term a cycle
  always_comb begin
    case (term_r)
      TERM_FB: begin
        mul_a = filt_r;
        mul_b = COEF_FB;
      end
      TERM_RAW: begin
        mul_a = raw_r;
        mul_b = COEF_FF;
      end
      TERM_PREV: begin
        mul_a = prev_raw_r;
        mul_b = COEF_FF;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Round half up, then saturate to the 35-bit range
  assign acc_rnd = acc_r + RND_HALF;
  assign rnd     = RND_W'(acc_rnd >>> FRAC_Q);

  always_comb begin
    if (rnd[RND_W-1:RPM_W-1] == '0 || rnd[RND_W-1:RPM_W-1] == '1) begin
      sat = rnd[RPM_W-1:0];
    end else if (rnd[RND_W-1]) begin
      sat = {1'b1, {(RPM_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(RPM_W-1){1'b1}}};
    end
  end

  // Sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    ppr_nxt       = ppr_r;
    en_nxt        = en_r;
    pos_nxt       = pos_r;
    dir_nxt       = dir_r;
    prev_time_nxt = prev_time_r;
    period_nxt    = period_r;
    filt_nxt      = filt_r;
    prev_raw_nxt  = prev_raw_r;
    raw_nxt       = raw_r;
    acc_nxt       = acc_r;
    term_nxt      = term_r;
    out_pos_nxt   = out_pos_r;
    out_dir_nxt   = out_dir_r;
    out_spd_nxt   = out_spd_r;

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        CFG_PPR: ppr_nxt = cfg_wdata[PPR_W-1:0];
        CFG_EN:  en_nxt  = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.req_type == REQ_EDGE) begin
            // Measure period, take direction, step position
            period_nxt    = in_chan.timestamp_us - prev_time_r;
            prev_time_nxt = in_chan.timestamp_us;
            if (in_chan.phase_b_level) begin
              dir_nxt = DIR_NEG;
              pos_nxt = pos_r - 1'b1;
            end else begin
              dir_nxt = DIR_POS;
              pos_nxt = pos_r + 1'b1;
            end
            out_pos_nxt = pos_nxt;
            out_dir_nxt = dir_nxt;
            out_spd_nxt = filt_r;
            state_nxt   = ST_OUT;
          end else if (!en_r) begin
            // Disabled read answers zero speed and keeps state
            out_pos_nxt = pos_r;
            out_dir_nxt = dir_r;
            out_spd_nxt = '0;
            state_nxt   = ST_OUT;
          end else if (dir_r == DIR_NONE) begin
            raw_nxt   = '0;
            acc_nxt   = '0;
            term_nxt  = TERM_FB;
            state_nxt = ST_FILT;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          raw_nxt   = dir_r[DIR_W-1] ? -mag : mag;
          acc_nxt   = '0;
          term_nxt  = TERM_FB;
          state_nxt = ST_FILT;
        end
      end
      ST_FILT: begin
        // Accumulate one filter term
        acc_nxt  = acc_r + ACC_W'(prod);
        term_nxt = term_r + 1'b1;
        if (term_r == TERM_PREV) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        filt_nxt     = sat;
        prev_raw_nxt = raw_r;
        dir_nxt      = DIR_NONE;
        out_pos_nxt  = pos_r;
        out_dir_nxt  = DIR_NONE;
        out_spd_nxt  = sat;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        // Hold the result until taken
        if (out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ppr_r       <= PPR_W'(1);
      en_r        <= 1'b0;
      pos_r       <= '0;
      dir_r       <= DIR_NONE;
      prev_time_r <= '0;
      period_r    <= '0;
      filt_r      <= '0;
      prev_raw_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      ppr_r       <= ppr_nxt;
      en_r        <= en_nxt;
      pos_r       <= pos_nxt;
      dir_r       <= dir_nxt;
      prev_time_r <= prev_time_nxt;
      period_r    <= period_nxt;
      filt_r      <= filt_nxt;
      prev_raw_r  <= prev_raw_nxt;
    end
    raw_r     <= raw_nxt;
    acc_r     <= acc_nxt;
    term_r    <= term_nxt;
    out_pos_r <= out_pos_nxt;
    out_dir_r <= out_dir_nxt;
    out_spd_r <= out_spd_nxt;
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = (state_r == ST_OUT);
  assign out_chan.position     = $signed(out_pos_r);
  assign out_chan.direction    = out_dir_r;
  assign out_chan.speed_rpm_q8 = out_spd_r;

endmodule
